### rtl/rae_pkg.sv
`timescale 1ns / 1ps
package rae_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS = 256;
	localparam int LABEL_BITS = 8;
	localparam int LABEL_COUNT = 1 << LABEL_BITS;

	// fixed register widths
	localparam int DIM_W = 9;
	localparam int SLICE_W = 16;
	localparam int THR_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_CW = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
	localparam int ROW_CW = (ROW_W + 1 > DIM_W) ? ROW_W + 1 : DIM_W;
	localparam int THR_CW = (LABEL_BITS > THR_W) ? LABEL_BITS : THR_W;

	localparam int WIN_DEPTH = MAX_COLUMNS * MAX_ROWS + MAX_COLUMNS + 1;
	localparam int WIN_AW = $clog2(WIN_DEPTH);
	localparam int OFF_W = $clog2(WIN_DEPTH + 1);
	localparam int PLANE_W = $clog2(MAX_COLUMNS * MAX_ROWS + 1);

	localparam int NBR_COUNT = 13;
	localparam int NBR_W = $clog2(NBR_COUNT + 1);

	localparam int IN_TDATA_W = ((LABEL_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * LABEL_BITS + 7) / 8) * 8;

	typedef logic [LABEL_BITS-1:0] label_t;
	typedef logic [LABEL_COUNT-1:0] pair_row_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMNS   = 2'd0,
		REG_ROWS      = 2'd1,
		REG_SLICES    = 2'd2,
		REG_THRESHOLD = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STEP_NEG  = 2'd0,
		STEP_ZERO = 2'd1,
		STEP_POS  = 2'd2
	} step_t;

	typedef struct packed {
		logic  back_slice;
		step_t dy;
		step_t dx;
	} nbr_dir_t;

	typedef struct packed {
		logic [DIM_W-1:0]   cols;
		logic [DIM_W-1:0]   rows;
		logic [SLICE_W-1:0] slices;
		logic [PLANE_W-1:0] plane;
		logic [THR_W-1:0]   thr;
	} geom_t;

	typedef struct packed {
		logic             rd_en;
		logic [OFF_W-1:0] off;
		logic             wr_en;
		label_t           wr_label;
	} win_req_t;

	typedef struct packed {
		logic      rd_en;
		label_t    rd_row;
		logic      wr_en;
		label_t    wr_row;
		pair_row_t wr_data;
		logic      clr;
	} pair_req_t;

	// earlier neighbours, oldest first
	function automatic nbr_dir_t nbr_dir(input logic [NBR_W-1:0] k);
		nbr_dir_t d;
		d = '{back_slice: 1'b0, dy: STEP_ZERO, dx: STEP_ZERO};
		case (k)
			4'd0:    d = '{1'b1, STEP_NEG,  STEP_NEG};
			4'd1:    d = '{1'b1, STEP_NEG,  STEP_ZERO};
			4'd2:    d = '{1'b1, STEP_NEG,  STEP_POS};
			4'd3:    d = '{1'b1, STEP_ZERO, STEP_NEG};
			4'd4:    d = '{1'b1, STEP_ZERO, STEP_ZERO};
			4'd5:    d = '{1'b1, STEP_ZERO, STEP_POS};
			4'd6:    d = '{1'b1, STEP_POS,  STEP_NEG};
			4'd7:    d = '{1'b1, STEP_POS,  STEP_ZERO};
			4'd8:    d = '{1'b1, STEP_POS,  STEP_POS};
			4'd9:    d = '{1'b0, STEP_NEG,  STEP_NEG};
			4'd10:   d = '{1'b0, STEP_NEG,  STEP_ZERO};
			4'd11:   d = '{1'b0, STEP_NEG,  STEP_POS};
			4'd12:   d = '{1'b0, STEP_ZERO, STEP_NEG};
			default: d = '{1'b0, STEP_ZERO, STEP_ZERO};
		endcase
		return d;
	endfunction

endpackage

### rtl/rae_win.sv
`timescale 1ns / 1ps
module rae_win (
	input  logic                clk,
	input  logic                arst_n,
	input  rae_pkg::win_req_t   req,
	output rae_pkg::label_t     rd_label
);

	localparam int DW = rae_pkg::OFF_W + 1;
	localparam logic [DW-1:0] DEPTH_X = DW'(rae_pkg::WIN_DEPTH);

	rae_pkg::label_t mem_q [rae_pkg::WIN_DEPTH];
	logic [rae_pkg::WIN_AW-1:0] wp_q;
	logic [DW-1:0] diff;
	logic [DW-1:0] wrap;
	logic [rae_pkg::WIN_AW-1:0] rd_addr;
	rae_pkg::label_t rd_q;

	// ring address: write pointer minus offset, wrapped into the ring
	assign diff = DW'(wp_q) - DW'(req.off);
	assign wrap = diff + DEPTH_X;
	assign rd_addr = diff[DW-1] ? rae_pkg::WIN_AW'(wrap) : rae_pkg::WIN_AW'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (req.wr_en) begin
			if (wp_q == rae_pkg::WIN_AW'(rae_pkg::WIN_DEPTH - 1)) begin
				wp_q <= '0;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[wp_q] <= req.wr_label;
		end
		if (req.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_label = rd_q;

endmodule

### rtl/rae_pair.sv
`timescale 1ns / 1ps
module rae_pair (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rae_pkg::pair_req_t   req,
	output rae_pkg::pair_row_t   rd_row_data
);

	rae_pkg::pair_row_t mem_q [rae_pkg::LABEL_COUNT];
	logic [rae_pkg::LABEL_COUNT-1:0] vld_q;
	rae_pkg::pair_row_t row_q;
	logic row_vld_q;

	// one valid bit per row: a row never written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			row_vld_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_row] <= 1'b1;
			end
			if (req.rd_en) begin
				row_vld_q <= vld_q[req.rd_row];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_row] <= req.wr_data;
		end
		if (req.rd_en) begin
			row_q <= mem_q[req.rd_row];
		end
	end

	assign rd_row_data = row_vld_q ? row_q : '0;

endmodule

### rtl/rae_ctrl.sv
`timescale 1ns / 1ps
module rae_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rae_pkg::geom_t       geom,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  rae_pkg::label_t      s_label,
	input  logic                 s_start,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output rae_pkg::label_t      m_src,
	output rae_pkg::label_t      m_nbr,
	output logic                 m_last,
	output rae_pkg::win_req_t    win_req,
	input  rae_pkg::label_t      win_label,
	output rae_pkg::pair_req_t   pair_req,
	input  rae_pkg::pair_row_t   pair_row
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_OFF  = 7'b0000010,
		S_ADDR = 7'b0000100,
		S_NBR  = 7'b0001000,
		S_CHK0 = 7'b0010000,
		S_CHK1 = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	rae_pkg::label_t lab_q, nl_q;
	logic [rae_pkg::NBR_W-1:0] k_q;
	logic [rae_pkg::OFF_W-1:0] off_q, off_d;
	logic [rae_pkg::COL_W-1:0] cpos_q;
	logic [rae_pkg::ROW_W-1:0] rpos_q;
	logic [rae_pkg::SLICE_W-1:0] zpos_q;

	logic pend_v_q;
	rae_pkg::label_t pend_src_q, pend_nbr_q;
	logic out_v_q, out_last_q;
	rae_pkg::label_t out_src_q, out_nbr_q;

	rae_pkg::nbr_dir_t dir;
	logic [rae_pkg::COL_CW-1:0] cpos_inc;
	logic [rae_pkg::ROW_CW-1:0] rpos_inc;
	logic [rae_pkg::SLICE_W:0] zpos_inc;
	logic cpos_end, rpos_end, zpos_end;
	logic nbr_ok;
	logic [rae_pkg::OFF_W-1:0] zterm, yterm, xterm;

	rae_pkg::label_t chk_centre, chk_other;
	logic in_chk, seen, thr_ok, hit, out_free, stall, emit_go, done_go, out_load, k_adv;
	logic accept;

	assign accept = (state_q == S_IDLE) && s_tvalid;
	assign s_tready = (state_q == S_IDLE);

	// neighbour bounds
	assign dir = rae_pkg::nbr_dir(k_q);
	assign cpos_inc = rae_pkg::COL_CW'(cpos_q) + 1'b1;
	assign rpos_inc = rae_pkg::ROW_CW'(rpos_q) + 1'b1;
	assign zpos_inc = {1'b0, zpos_q} + 1'b1;
	assign cpos_end = cpos_inc >= rae_pkg::COL_CW'(geom.cols);
	assign rpos_end = rpos_inc >= rae_pkg::ROW_CW'(geom.rows);
	assign zpos_end = zpos_inc >= {1'b0, geom.slices};

	assign nbr_ok = !(dir.back_slice && zpos_q == '0)
		&& !(dir.dy == rae_pkg::STEP_NEG && rpos_q == '0)
		&& !(dir.dy == rae_pkg::STEP_POS && rpos_end)
		&& !(dir.dx == rae_pkg::STEP_NEG && cpos_q == '0)
		&& !(dir.dx == rae_pkg::STEP_POS && cpos_end);

	// backward distance in the ring: plane, row and column terms
	always_comb begin
		zterm = dir.back_slice ? rae_pkg::OFF_W'(geom.plane) : '0;
		case (dir.dy)
			rae_pkg::STEP_NEG: yterm = rae_pkg::OFF_W'(geom.cols);
			rae_pkg::STEP_POS: yterm = '0 - rae_pkg::OFF_W'(geom.cols);
			default:           yterm = '0;
		endcase
		case (dir.dx)
			rae_pkg::STEP_NEG: xterm = rae_pkg::OFF_W'(1);
			rae_pkg::STEP_POS: xterm = '1;
			default:           xterm = '0;
		endcase
	end
	assign off_d = zterm + yterm + xterm;

	// pair check: first the current voxel as centre, then the neighbour
	assign in_chk = (state_q == S_CHK0) || (state_q == S_CHK1);
	assign chk_centre = (state_q == S_CHK1) ? nl_q : lab_q;
	assign chk_other = (state_q == S_CHK1) ? lab_q : nl_q;
	assign seen = pair_row[chk_other];
	assign thr_ok = rae_pkg::THR_CW'(chk_centre) >= rae_pkg::THR_CW'(geom.thr);
	assign hit = in_chk && thr_ok && !seen;

	assign out_free = !out_v_q || m_tready;
	assign stall = hit && pend_v_q && !out_free;
	assign emit_go = hit && !stall;
	assign done_go = (state_q == S_DONE) && (!pend_v_q || out_free);
	assign out_load = (emit_go || done_go) && pend_v_q;

	always_comb begin
		state_d = state_q;
		k_adv = 1'b0;
		win_req = '0;
		pair_req = '0;
		unique case (state_q)
			S_IDLE: begin
				pair_req.clr = accept && s_start;
				if (s_tvalid) begin
					state_d = S_OFF;
				end
			end
			S_OFF: begin
				if (lab_q == '0 || k_q == rae_pkg::NBR_W'(rae_pkg::NBR_COUNT)) begin
					state_d = S_DONE;
				end else if (nbr_ok) begin
					state_d = S_ADDR;
				end else begin
					k_adv = 1'b1;
				end
			end
			S_ADDR: begin
				win_req.rd_en = 1'b1;
				win_req.off = off_q;
				state_d = S_NBR;
			end
			S_NBR: begin
				if (win_label == '0 || win_label == lab_q) begin
					k_adv = 1'b1;
					state_d = S_OFF;
				end else begin
					pair_req.rd_en = 1'b1;
					pair_req.rd_row = lab_q;
					state_d = S_CHK0;
				end
			end
			S_CHK0: begin
				if (!stall) begin
					pair_req.rd_en = 1'b1;
					pair_req.rd_row = nl_q;
					pair_req.wr_en = hit;
					pair_req.wr_row = chk_centre;
					pair_req.wr_data = pair_row | (rae_pkg::LABEL_COUNT'(1) << chk_other);
					state_d = S_CHK1;
				end
			end
			S_CHK1: begin
				if (!stall) begin
					pair_req.wr_en = hit;
					pair_req.wr_row = chk_centre;
					pair_req.wr_data = pair_row | (rae_pkg::LABEL_COUNT'(1) << chk_other);
					k_adv = 1'b1;
					state_d = S_OFF;
				end
			end
			S_DONE: begin
				if (done_go) begin
					win_req.wr_en = 1'b1;
					win_req.wr_label = lab_q;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			cpos_q <= '0;
			rpos_q <= '0;
			zpos_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				k_q <= '0;
				if (s_start) begin
					cpos_q <= '0;
					rpos_q <= '0;
					zpos_q <= '0;
				end
			end else if (k_adv) begin
				k_q <= k_q + 1'b1;
			end
			// advance raster position once the voxel is finished
			if (done_go) begin
				if (cpos_end) begin
					cpos_q <= '0;
					if (rpos_end) begin
						rpos_q <= '0;
						zpos_q <= zpos_end ? '0 : rae_pkg::SLICE_W'(zpos_inc);
					end else begin
						rpos_q <= rae_pkg::ROW_W'(rpos_inc);
					end
				end else begin
					cpos_q <= rae_pkg::COL_W'(cpos_inc);
				end
			end
			if (emit_go) begin
				pend_v_q <= 1'b1;
			end else if (done_go) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// hold the newest pair back so the last one of a voxel can be flagged
	always_ff @(posedge clk) begin
		if (accept) begin
			lab_q <= s_label;
		end
		if (state_q == S_OFF) begin
			off_q <= off_d;
		end
		if (state_q == S_NBR) begin
			nl_q <= win_label;
		end
		if (emit_go) begin
			pend_src_q <= chk_centre;
			pend_nbr_q <= chk_other;
		end
		if (out_load) begin
			out_src_q <= pend_src_q;
			out_nbr_q <= pend_nbr_q;
			out_last_q <= done_go;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_src = out_src_q;
	assign m_nbr = out_nbr_q;
	assign m_last = out_last_q;

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("pending pair left behind at end of voxel");

	a_nbr_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (k_q <= rae_pkg::NBR_W'(rae_pkg::NBR_COUNT)))
		else $error("neighbour counter out of range");

	a_pair_labels: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_src_q != out_nbr_q) && (out_src_q != '0) && (out_nbr_q != '0))
		else $error("pair with background or equal labels");

	a_chk_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK1) |-> ($past(state_q) == S_CHK0 || $past(state_q) == S_CHK1))
		else $error("reverse check entered out of order");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_v_q || m_tready))
		else $error("output register overwritten while full");

endmodule

### rtl/region_adjacency_extract_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata: voxel_label; s_tuser: volume_start
// m_*       out        m_tvalid / m_tready  m_tdata: source_label, neighbor_label; m_tlast
// cfg_*     in         cfg_valid/cfg_ready  cfg_index: register; cfg_data: value
//
// One voxel at a time: each neighbour outside the volume is skipped, each one inside is read
// from the window ring, and each differing nonzero neighbour then takes the two
// pair-matrix checks (one window read port, one pair-matrix row port, used in turn).
// A background voxel skips the neighbour reads altogether.
// Reset clears positions, ring pointer and the pair-matrix row valid bits; no clearing pass.
// The block stalls before taking a new pair while a pair is pending and the output register is still full.
module region_adjacency_extract_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [rae_pkg::IN_TDATA_W-1:0]        s_tdata,   // [7:0] voxel_label
	input  logic                                  s_tuser,   // [0] volume_start
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [rae_pkg::OUT_TDATA_W-1:0]       m_tdata,   // [7:0] source_label, [15:8] neighbor_label
	output logic                                  m_tlast,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rae_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rae_pkg::CFG_DATA_W-1:0]        cfg_data
);

	logic [rae_pkg::DIM_W-1:0] cols_q, rows_q, cols_c, rows_c;
	logic [rae_pkg::SLICE_W-1:0] slices_q;
	logic [rae_pkg::THR_W-1:0] thr_q;
	logic [2*rae_pkg::DIM_W-1:0] plane_prod;
	logic [rae_pkg::PLANE_W-1:0] plane_q;
	rae_pkg::geom_t geom;
	rae_pkg::win_req_t win_req;
	rae_pkg::label_t win_label;
	rae_pkg::pair_req_t pair_req;
	rae_pkg::pair_row_t pair_row;
	rae_pkg::label_t m_src, m_nbr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= rae_pkg::DIM_W'(256);
			rows_q <= rae_pkg::DIM_W'(256);
			slices_q <= rae_pkg::SLICE_W'(256);
			thr_q <= rae_pkg::THR_W'(1);
		end else if (cfg_valid) begin
			unique case (rae_pkg::cfg_reg_t'(cfg_index))
				rae_pkg::REG_COLUMNS:   cols_q <= cfg_data[rae_pkg::DIM_W-1:0];
				rae_pkg::REG_ROWS:      rows_q <= cfg_data[rae_pkg::DIM_W-1:0];
				rae_pkg::REG_SLICES:    slices_q <= cfg_data[rae_pkg::SLICE_W-1:0];
				rae_pkg::REG_THRESHOLD: thr_q <= cfg_data[rae_pkg::THR_W-1:0];
			endcase
		end
	end

	// clamp sizes to the supported range
	always_comb begin
		cols_c = cols_q;
		if (cols_q == '0) begin
			cols_c = rae_pkg::DIM_W'(1);
		end else if (int'(cols_q) > rae_pkg::MAX_COLUMNS) begin
			cols_c = rae_pkg::DIM_W'(rae_pkg::MAX_COLUMNS);
		end
		rows_c = rows_q;
		if (rows_q == '0) begin
			rows_c = rae_pkg::DIM_W'(1);
		end else if (int'(rows_q) > rae_pkg::MAX_ROWS) begin
			rows_c = rae_pkg::DIM_W'(rae_pkg::MAX_ROWS);
		end
	end

	assign plane_prod = (2*rae_pkg::DIM_W)'(cols_c) * (2*rae_pkg::DIM_W)'(rows_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else begin
			plane_q <= rae_pkg::PLANE_W'(plane_prod);
		end
	end

	assign geom.cols = cols_c;
	assign geom.rows = rows_c;
	assign geom.slices = (slices_q == '0) ? rae_pkg::SLICE_W'(1) : slices_q;
	assign geom.plane = plane_q;
	assign geom.thr = thr_q;

	rae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_label   (s_tdata[rae_pkg::LABEL_BITS-1:0]),
		.s_start   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_src     (m_src),
		.m_nbr     (m_nbr),
		.m_last    (m_tlast),
		.win_req   (win_req),
		.win_label (win_label),
		.pair_req  (pair_req),
		.pair_row  (pair_row)
	);

	rae_win u_win (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (win_req),
		.rd_label (win_label)
	);

	rae_pair u_pair (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (pair_req),
		.rd_row_data (pair_row)
	);

	assign m_tdata = rae_pkg::OUT_TDATA_W'({m_nbr, m_src});

endmodule

### tb/sv/region_adjacency_extract_core_tb.sv
`timescale 1ns / 1ps
module region_adjacency_extract_core_tb;
	import rae_pkg::*;

	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES = 600;
	localparam int RANDOM_VOXELS = 70;

	typedef struct {
		label_t src;
		label_t nbr;
		logic   tail;
	} pair_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// predictor state, mirrors the block after reset
	logic [DIM_W-1:0]   cols_reg = 9'd256;
	logic [DIM_W-1:0]   rows_reg = 9'd256;
	logic [SLICE_W-1:0] slices_reg = 16'd256;
	logic [THR_W-1:0]   thr_reg = 8'd1;
	label_t             voxel_ring [WIN_DEPTH] = '{default: '0};
	int                 ring_wp = 0;
	bit [LABEL_COUNT-1:0] pair_map [LABEL_COUNT];
	int                 col_pos = 0;
	int                 row_pos = 0;
	int                 slice_pos = 0;

	pair_t pending_pairs[$];
	int    mismatch_count = 0;
	bit    tx_steady = 1'b0;
	bit    rx_steady = 1'b0;
	bit    hold_outputs = 1'b0;

	region_adjacency_extract_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int fit_dim(input int v, input int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic int pick_gap(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int note_pair(input label_t centre, input label_t other);
		pair_t p;
		if (centre < thr_reg) return 0;
		if (pair_map[centre][other]) return 0;
		pair_map[centre][other] = 1'b1;
		p.src = centre;
		p.nbr = other;
		p.tail = 1'b0;
		pending_pairs.push_back(p);
		return 1;
	endfunction

	task automatic predict_new_pairs(input label_t lab, input logic first);
		int c, r, s, k, dz, dy, dx, off, idx, found;
		label_t nl;
		c = fit_dim(cols_reg, MAX_COLUMNS);
		r = fit_dim(rows_reg, MAX_ROWS);
		s = (slices_reg == 0) ? 1 : slices_reg;
		found = 0;
		if (first) begin
			col_pos = 0;
			row_pos = 0;
			slice_pos = 0;
			foreach (pair_map[i]) pair_map[i] = '0;
		end
		if (lab != 0) begin
			// previous slice as a 3x3 block, then the row above, then the left voxel
			for (k = 0; k < NBR_COUNT; k++) begin
				dz = (k < 9) ? -1 : 0;
				dy = (k < 9) ? k / 3 - 1 : ((k < 12) ? -1 : 0);
				dx = (k < 9) ? k % 3 - 1 : ((k < 12) ? k - 10 : -1);
				if (dz < 0 && slice_pos == 0) continue;
				if (dy < 0 && row_pos == 0) continue;
				if (dy > 0 && row_pos + 1 >= r) continue;
				if (dx < 0 && col_pos == 0) continue;
				if (dx > 0 && col_pos + 1 >= c) continue;
				off = -(dz * c * r + dy * c + dx);
				if (off < 1 || off > WIN_DEPTH) continue;
				idx = (ring_wp + WIN_DEPTH - off) % WIN_DEPTH;
				nl = voxel_ring[idx];
				if (nl == 0 || nl == lab) continue;
				found += note_pair(lab, nl);
				found += note_pair(nl, lab);
			end
		end
		voxel_ring[ring_wp] = lab;
		ring_wp = (ring_wp + 1) % WIN_DEPTH;
		col_pos++;
		if (col_pos >= c) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= r) begin
				row_pos = 0;
				slice_pos++;
				if (slice_pos >= s) slice_pos = 0;
			end
		end
		if (found > 0) pending_pairs[pending_pairs.size() - 1].tail = 1'b1;
	endtask

	// hold each request until accepted; leave tvalid high when the next follows at once
	task automatic send_voxel(input label_t lab, input logic first);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'(lab);
		s_tuser <= first;
		do @(posedge clk); while (!s_tready);
		predict_new_pairs(lab, first);
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_labels(input label_t labels[$]);
		foreach (labels[i]) send_voxel(labels[i], i == 0);
		s_tvalid <= 1'b0;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_COLUMNS:   cols_reg = value[DIM_W-1:0];
			REG_ROWS:      rows_reg = value[DIM_W-1:0];
			REG_SLICES:    slices_reg = value[SLICE_W-1:0];
			REG_THRESHOLD: thr_reg = value[THR_W-1:0];
			default:       ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_pairs.size() != 0) @(posedge clk);
		// a voxel with no new pair may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure_volume(input int cols, input int rows, input int slices,
			input int thr);
		wait_idle();
		write_reg(REG_COLUMNS, CFG_DATA_W'(cols));
		write_reg(REG_ROWS, CFG_DATA_W'(rows));
		write_reg(REG_SLICES, CFG_DATA_W'(slices));
		write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
		cfg_valid <= 1'b0;
	endtask

	function automatic label_t pick_label(input label_t palette[4]);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return '0;
		if (r < 22) return label_t'($urandom_range(0, 255));
		return palette[$urandom_range(0, 3)];
	endfunction

	task automatic fill_palette(output label_t palette[4]);
		foreach (palette[i]) palette[i] = label_t'($urandom_range(1, 255));
	endtask

	// every direction around one centre voxel is new: the full 26 pairs at once
	task automatic test_full_neighbourhood();
		label_t seq[$];
		configure_volume(3, 3, 2, 0);
		seq = '{8'd255, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128,
			8'd127, 8'd191, 8'd223, 8'd239, 8'd170, 8'd0, 8'd170};
		send_labels(seq);
	endtask

	// only the top label may act as centre; pairs survive a wrap but not a restart
	task automatic test_threshold_and_wrap();
		label_t seq[$];
		configure_volume(4, 1, 1, 255);
		seq = '{8'd255, 8'd254, 8'd255, 8'd0, 8'd254, 8'd255};
		send_labels(seq);
		seq = '{8'd254, 8'd255, 8'd1, 8'd255};
		send_labels(seq);
	endtask

	task automatic test_register_extremes();
		label_t seq[$];
		label_t palette[4];
		configure_volume(0, 0, 0, 1);
		seq = '{8'd255, 8'd1, 8'd255, 8'd2};
		send_labels(seq);
		configure_volume(511, 1, 65535, 128);
		fill_palette(palette);
		seq = {};
		repeat (12) seq.push_back(pick_label(palette));
		send_labels(seq);
		configure_volume(1, 256, 1, 1);
		fill_palette(palette);
		seq = {};
		repeat (10) seq.push_back(pick_label(palette));
		send_labels(seq);
		configure_volume(256, 257, 1, 0);
		fill_palette(palette);
		seq = {};
		repeat (8) seq.push_back(pick_label(palette));
		send_labels(seq);
	endtask

	// mostly whole small volumes with a few labels; some cut short, restarted or wrapped
	task automatic test_random_volumes();
		int cols, rows, slices, size, n, r, sent;
		label_t palette[4];
		label_t lab;
		logic first;
		sent = 0;
		while (sent < RANDOM_VOXELS) begin
			cols = $urandom_range(1, 5);
			rows = $urandom_range(1, 4);
			slices = $urandom_range(1, 4);
			r = $urandom_range(0, 99);
			configure_volume(cols, rows, slices,
				(r < 50) ? 1 : (r < 70) ? 0 : (r < 95) ? $urandom_range(0, 255) : 255);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			fill_palette(palette);
			size = cols * rows * slices;
			n = ($urandom_range(0, 99) < 15) ? $urandom_range(1, size)
				: size + $urandom_range(0, 3);
			lab = pick_label(palette);
			for (int i = 0; i < n; i++) begin
				first = (i == 0) || ($urandom_range(0, 99) < 3);
				if ($urandom_range(0, 99) >= 40) lab = pick_label(palette);
				send_voxel(lab, first);
			end
			s_tvalid <= 1'b0;
			sent += n;
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// stall the output long enough for the block to back up into its input
	task automatic test_output_backpressure();
		label_t seq[$];
		configure_volume(3, 3, 2, 0);
		repeat (18) seq.push_back(label_t'($urandom_range(1, 255)));
		tx_steady = 1'b1;
		hold_outputs = 1'b1;
		send_labels(seq);
		tx_steady = 1'b0;
	endtask

	initial begin : result_receiver
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_outputs) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_outputs = 1'b0;
			end
			stall = pick_gap(rx_steady);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		pair_t want;
		label_t got_src, got_nbr;
		if (arst_n && m_tvalid && m_tready) begin
			got_src = m_tdata[LABEL_BITS-1:0];
			got_nbr = m_tdata[2*LABEL_BITS-1:LABEL_BITS];
			if (pending_pairs.size() == 0) begin
				$display("%0t: pair with none expected: src %0d nbr %0d last %0b",
					$time, got_src, got_nbr, m_tlast);
				mismatch_count++;
			end else begin
				want = pending_pairs.pop_front();
				if (got_src !== want.src) begin
					$display("%0t: source_label expected %0d actual %0d",
						$time, want.src, got_src);
					mismatch_count++;
				end
				if (got_nbr !== want.nbr) begin
					$display("%0t: neighbor_label expected %0d actual %0d",
						$time, want.nbr, got_nbr);
					mismatch_count++;
				end
				if (m_tlast !== want.tail) begin
					$display("%0t: last_pair expected %0b actual %0b",
						$time, want.tail, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_full_neighbourhood();
		test_threshold_and_wrap();
		test_register_extremes();
		test_random_volumes();
		test_output_backpressure();
		wait_idle();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### region_adjacency_extract_core.f
rtl/rae_pkg.sv
rtl/rae_win.sv
rtl/rae_pair.sv
rtl/rae_ctrl.sv
rtl/region_adjacency_extract_core.sv
tb/sv/region_adjacency_extract_core_tb.sv
